/* rtl/core/mfpr_pkg.sv */
package mfpr_pkg;

   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam int unsigned CSR_DATA_WIDTH  = 8;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_START_MARKER   = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_END_MARKER     = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HUNT_FOR_START = 2'd2;

   localparam logic [7:0] RESET_START_MARKER   = 8'h02;
   localparam logic [7:0] RESET_END_MARKER     = 8'h03;
   localparam logic       RESET_HUNT_FOR_START = 1'b1;

   localparam logic [1:0] STATUS_OK          = 2'd0;
   localparam logic [1:0] STATUS_MISSING_END = 2'd1;
   localparam logic [1:0] STATUS_BAD_CHECK   = 2'd2;
   localparam logic [1:0] STATUS_BAD_LENGTH  = 2'd3;

   localparam logic [7:0]  STUFF_BYTE        = 8'hff;
   localparam logic [15:0] MIN_FRAME_LENGTH  = 16'd7;
   localparam logic [15:0] HEADER_BYTES      = 16'd4;
   localparam logic [15:0] CHECK_HIGH_OFFSET = 16'd3;
   localparam logic [15:0] CHECK_LOW_OFFSET  = 16'd2;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'b001,
      PH_HEADER = 3'b010,
      PH_BODY   = 3'b100
   } phase_type;

   typedef struct packed {
      logic [7:0] start_marker;
      logic [7:0] end_marker;
      logic       hunt_for_start;
   } cfg_type;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        is_end;
      logic [1:0]  status;
      logic [7:0]  seq_number;
      logic [15:0] packet_length;
   } result_type;

   // Residue of a 16-bit value modulo 255, using 256 == 1 (mod 255).
   function automatic logic [7:0] mod255(input logic [15:0] x);
      logic [8:0] s;
      logic [8:0] t;
      s = {1'b0, x[15:8]} + {1'b0, x[7:0]};
      t = {8'b0, s[8]} + {1'b0, s[7:0]};
      return (t[7:0] == 8'hff) ? 8'h00 : t[7:0];
   endfunction

endpackage

/* rtl/core/mfpr_if.sv */
interface mfpr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface mfpr_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  data_byte;
   logic        is_end;
   logic [1:0]  status;
   logic [7:0]  seq_number;
   logic [15:0] packet_length;

   modport source (output valid, output data_byte, output is_end, output status,
                   output seq_number, output packet_length, input ready);
   modport sink (input valid, input data_byte, input is_end, input status,
                 input seq_number, input packet_length, output ready);
endinterface

/* rtl/core/mfpr_csr.sv */
module mfpr_csr
   import mfpr_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data,
   output cfg_type                    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_START_MARKER:   cfg_in.start_marker = csr_write_data[7:0];
            CSR_END_MARKER:     cfg_in.end_marker = csr_write_data[7:0];
            CSR_HUNT_FOR_START: cfg_in.hunt_for_start = csr_write_data[0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_marker   <= RESET_START_MARKER;
         cfg_ff.end_marker     <= RESET_END_MARKER;
         cfg_ff.hunt_for_start <= RESET_HUNT_FOR_START;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/core/mfpr_in_stage.sv */
module mfpr_in_stage
   import mfpr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   mfpr_req_if.sink   req_chan,
   input  logic       advance,
   output logic       fire,
   output logic [7:0] held_byte
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;
   logic       take;

   assign req_chan.ready = !valid_ff || advance;
   assign take           = req_chan.valid && req_chan.ready;
   assign fire           = valid_ff && advance;
   assign valid_in       = take ? 1'b1 : (fire ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         byte_ff <= req_chan.rx_byte;
      end
   end

   assign held_byte = byte_ff;

endmodule

/* rtl/core/mfpr_deframer.sv */
module mfpr_deframer
   import mfpr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       fire,
   input  logic [7:0] rx_byte,
   output logic       result_valid,
   output result_type result
);

   phase_type   phase_ff,        phase_in;
   logic [1:0]  header_count_ff, header_count_in;
   logic [7:0]  seq_store_ff,    seq_store_in;
   logic [15:0] frame_length_ff, frame_length_in;
   logic [15:0] stored_count_ff, stored_count_in;
   logic [15:0] running_sum_ff,  running_sum_in;
   logic        after_ff_ff,     after_ff_in;
   logic [7:0]  check_high_ff,   check_high_in;
   logic [7:0]  check_low_ff,    check_low_in;

   logic [15:0] sum_add;
   logic [15:0] count_add;
   logic [15:0] length_new;
   logic [15:0] check_high_pos;
   logic [15:0] check_low_pos;
   logic        is_stuff;
   logic        check_match;

   assign sum_add        = running_sum_ff + {8'h00, rx_byte};
   assign count_add      = stored_count_ff + 16'd1;
   assign length_new     = {frame_length_ff[15:8], rx_byte};
   assign check_high_pos = frame_length_ff - CHECK_HIGH_OFFSET;
   assign check_low_pos  = frame_length_ff - CHECK_LOW_OFFSET;
   assign is_stuff       = (rx_byte == STUFF_BYTE);
   assign check_match    = (mod255(running_sum_ff) == mod255({check_high_ff, check_low_ff}));

   always_comb begin
      phase_in        = phase_ff;
      header_count_in = header_count_ff;
      seq_store_in    = seq_store_ff;
      frame_length_in = frame_length_ff;
      stored_count_in = stored_count_ff;
      running_sum_in  = running_sum_ff;
      after_ff_in     = after_ff_ff;
      check_high_in   = check_high_ff;
      check_low_in    = check_low_ff;
      result_valid    = 1'b0;
      result.data_byte     = 8'h00;
      result.is_end        = 1'b0;
      result.status        = STATUS_OK;
      result.seq_number    = seq_store_ff;
      result.packet_length = frame_length_ff;

      if (fire) begin
         case (phase_ff)
            PH_IDLE: begin
               if (!cfg.hunt_for_start || rx_byte == cfg.start_marker) begin
                  running_sum_in  = {8'h00, rx_byte};
                  header_count_in = 2'd1;
                  stored_count_in = 16'd1;
                  seq_store_in    = 8'h00;
                  frame_length_in = 16'h0000;
                  after_ff_in     = 1'b0;
                  check_high_in   = 8'h00;
                  check_low_in    = 8'h00;
                  phase_in        = PH_HEADER;
               end
            end
            PH_HEADER: begin
               running_sum_in  = sum_add;
               header_count_in = header_count_ff + 2'd1;
               stored_count_in = count_add;
               case (header_count_ff)
                  2'd1:    seq_store_in = rx_byte;
                  2'd2:    frame_length_in = {rx_byte, 8'h00};
                  default: frame_length_in = length_new;
               endcase
               if (count_add == HEADER_BYTES) begin
                  header_count_in = 2'd0;
                  after_ff_in     = 1'b0;
                  if (length_new < MIN_FRAME_LENGTH) begin
                     phase_in             = PH_IDLE;
                     result_valid         = 1'b1;
                     result.is_end        = 1'b1;
                     result.status        = STATUS_BAD_LENGTH;
                     result.packet_length = length_new;
                  end else begin
                     phase_in = PH_BODY;
                  end
               end
            end
            PH_BODY: begin
               if (is_stuff && after_ff_ff) begin
                  after_ff_in = 1'b0;
               end else begin
                  after_ff_in     = is_stuff;
                  stored_count_in = count_add;
                  if (stored_count_ff < check_high_pos) begin
                     running_sum_in   = sum_add;
                     result_valid     = 1'b1;
                     result.data_byte = rx_byte;
                  end else if (stored_count_ff == check_high_pos) begin
                     check_high_in = rx_byte;
                  end else if (stored_count_ff == check_low_pos) begin
                     check_low_in = rx_byte;
                  end else begin
                     phase_in      = PH_IDLE;
                     result_valid  = 1'b1;
                     result.is_end = 1'b1;
                     if (rx_byte != cfg.end_marker) begin
                        result.status = STATUS_MISSING_END;
                     end else if (!check_match) begin
                        result.status = STATUS_BAD_CHECK;
                     end else begin
                        result.status = STATUS_OK;
                     end
                  end
               end
            end
            default: phase_in = PH_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         header_count_ff <= 2'd0;
         seq_store_ff    <= 8'h00;
         frame_length_ff <= 16'h0000;
         stored_count_ff <= 16'h0000;
         running_sum_ff  <= 16'h0000;
         after_ff_ff     <= 1'b0;
         check_high_ff   <= 8'h00;
         check_low_ff    <= 8'h00;
      end else begin
         phase_ff        <= phase_in;
         header_count_ff <= header_count_in;
         seq_store_ff    <= seq_store_in;
         frame_length_ff <= frame_length_in;
         stored_count_ff <= stored_count_in;
         running_sum_ff  <= running_sum_in;
         after_ff_ff     <= after_ff_in;
         check_high_ff   <= check_high_in;
         check_low_ff    <= check_low_in;
      end
   end

endmodule

/* rtl/core/mfpr_out_reg.sv */
module mfpr_out_reg
   import mfpr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       result_valid,
   input  result_type result,
   output logic       advance,
   mfpr_rsp_if.source rsp_chan
);

   logic       valid_ff;
   logic       valid_in;
   result_type result_ff;

   assign advance  = !valid_ff || rsp_chan.ready;
   assign valid_in = advance ? result_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && result_valid) begin
         result_ff <= result;
      end
   end

   assign rsp_chan.valid         = valid_ff;
   assign rsp_chan.data_byte     = result_ff.data_byte;
   assign rsp_chan.is_end        = result_ff.is_end;
   assign rsp_chan.status        = result_ff.status;
   assign rsp_chan.seq_number    = result_ff.seq_number;
   assign rsp_chan.packet_length = result_ff.packet_length;

endmodule

/* rtl/core/marker_framed_packet_receiver_core.sv */
// Receives raw serial bytes on the req channel, one byte per transfer, and
// deframes marker-framed packets: start byte, sequence byte, 16-bit length,
// a body with doubled 0xff collapsed, a 16-bit checksum and an end marker.
// The rsp channel carries one transfer per de-stuffed payload byte and one
// closing status transfer per packet; header, checksum and dropped stuffing
// bytes produce no transfer.
// A byte accepted on req is held in an input register; when the output
// register can advance, the deframing logic processes it and loads its result
// into the output register, from which it shows on rsp. One byte is accepted
// every cycle unless rsp ready low holds the output register.
// The csr port writes the start marker, the end marker and the hunt flag at
// any edge with the write enable high, and is meant to be used while idle.
// Synchronous reset restores the register defaults, returns the deframer to
// hunting for a packet start and drops any byte or result in flight.
// When the receiver holds rsp ready low, the output register keeps its
// transfer, the input register then fills, and req ready drops until the
// result is taken; nothing is lost.
module marker_framed_packet_receiver_core
   import mfpr_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   mfpr_req_if.sink                   req_chan,
   mfpr_rsp_if.source                 rsp_chan,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data
);

   cfg_type    cfg;
   logic       advance;
   logic       fire;
   logic [7:0] held_byte;
   logic       result_valid;
   result_type result;

   mfpr_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   mfpr_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .advance   (advance),
      .fire      (fire),
      .held_byte (held_byte)
   );

   mfpr_deframer u_deframer (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .fire         (fire),
      .rx_byte      (held_byte),
      .result_valid (result_valid),
      .result       (result)
   );

   mfpr_out_reg u_out_reg (
      .clock        (clock),
      .reset        (reset),
      .result_valid (result_valid),
      .result       (result),
      .advance      (advance),
      .rsp_chan     (rsp_chan)
   );

endmodule

/* rtl/core/mfpr_checker.sv */
module mfpr_checker
   import mfpr_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_data_byte,
   input logic        rsp_is_end,
   input logic [1:0]  rsp_status,
   input logic [7:0]  rsp_seq_number,
   input logic [15:0] rsp_packet_length
);

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data_byte) &&
      $stable(rsp_is_end) && $stable(rsp_status) && $stable(rsp_seq_number) &&
      $stable(rsp_packet_length))
      else $error("stalled rsp transfer changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_end |-> rsp_status == STATUS_OK)
      else $error("payload transfer with nonzero status");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_end |->
      rsp_data_byte == 8'h00 &&
      ((rsp_status == STATUS_BAD_LENGTH) == (rsp_packet_length < MIN_FRAME_LENGTH)))
      else $error("status transfer inconsistent with length");

endmodule

bind marker_framed_packet_receiver_core mfpr_checker u_mfpr_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_data_byte     (rsp_chan.data_byte),
   .rsp_is_end        (rsp_chan.is_end),
   .rsp_status        (rsp_chan.status),
   .rsp_seq_number    (rsp_chan.seq_number),
   .rsp_packet_length (rsp_chan.packet_length)
);

/* test/marker_framed_packet_receiver_core_checker.sv */
`timescale 1ns / 1ps
module marker_framed_packet_receiver_core_checker
   import mfpr_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   mfpr_req_if                        req_mon,
   mfpr_rsp_if                        rsp_mon,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data,
   output int                         mismatch_count,
   output int                         pending_count
);

   cfg_type     cfg;
   phase_type   phase;
   logic [1:0]  header_seen;
   logic [7:0]  seq_byte;
   logic [15:0] frame_len;
   logic [15:0] kept_count;
   logic [15:0] byte_sum;
   logic        ff_kept;
   logic [7:0]  check_hi;
   logic [7:0]  check_lo;
   result_type  expected_results[$];

   initial mismatch_count = 0;

   task automatic report_mismatch(input string field, input int unsigned got,
                                  input int unsigned want);
      $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, field, got, want);
      mismatch_count++;
   endtask

   task automatic reset_deframer();
      cfg.start_marker   = RESET_START_MARKER;
      cfg.end_marker     = RESET_END_MARKER;
      cfg.hunt_for_start = RESET_HUNT_FOR_START;
      phase       = PH_IDLE;
      header_seen = '0;
      seq_byte    = '0;
      frame_len   = '0;
      kept_count  = '0;
      byte_sum    = '0;
      ff_kept     = 1'b0;
      check_hi    = '0;
      check_lo    = '0;
      expected_results.delete();
   endtask

   function automatic void expect_item(input logic [7:0] data, input logic closing,
                                       input logic [1:0] status);
      result_type r;
      r.data_byte     = data;
      r.is_end        = closing;
      r.status        = status;
      r.seq_number    = seq_byte;
      r.packet_length = frame_len;
      expected_results.push_back(r);
   endfunction

   task automatic deframe_byte(input logic [7:0] b);
      logic [15:0] pos;
      logic [1:0]  status;
      case (phase)
         PH_IDLE: begin
            if (cfg.hunt_for_start && b != cfg.start_marker) return;
            byte_sum    = {8'h00, b};
            header_seen = 2'd1;
            kept_count  = 16'd1;
            seq_byte    = '0;
            frame_len   = '0;
            ff_kept     = 1'b0;
            check_hi    = '0;
            check_lo    = '0;
            phase       = PH_HEADER;
         end
         PH_HEADER: begin
            byte_sum = byte_sum + {8'h00, b};
            case (header_seen)
               2'd1: seq_byte = b;
               2'd2: frame_len = {b, 8'h00};
               default: frame_len[7:0] = b;
            endcase
            header_seen = header_seen + 2'd1;
            kept_count  = kept_count + 16'd1;
            if (kept_count == HEADER_BYTES) begin
               header_seen = '0;
               ff_kept     = 1'b0;
               if (frame_len < MIN_FRAME_LENGTH) begin
                  phase = PH_IDLE;
                  expect_item(8'h00, 1'b1, STATUS_BAD_LENGTH);
               end else begin
                  phase = PH_BODY;
               end
            end
         end
         default: begin
            // A second 0xff right after a kept one is stuffing and vanishes.
            if (b == STUFF_BYTE) begin
               if (ff_kept) begin
                  ff_kept = 1'b0;
                  return;
               end
               ff_kept = 1'b1;
            end else begin
               ff_kept = 1'b0;
            end
            pos        = kept_count;
            kept_count = kept_count + 16'd1;
            if (pos < frame_len - CHECK_HIGH_OFFSET) begin
               byte_sum = byte_sum + {8'h00, b};
               expect_item(b, 1'b0, STATUS_OK);
            end else if (pos == frame_len - CHECK_HIGH_OFFSET) begin
               check_hi = b;
            end else if (pos == frame_len - CHECK_LOW_OFFSET) begin
               check_lo = b;
            end else begin
               phase = PH_IDLE;
               if (b != cfg.end_marker) begin
                  status = STATUS_MISSING_END;
               end else if ((int'(byte_sum) % 255) != (int'({check_hi, check_lo}) % 255)) begin
                  status = STATUS_BAD_CHECK;
               end else begin
                  status = STATUS_OK;
               end
               expect_item(8'h00, 1'b1, status);
            end
         end
      endcase
   endtask

   task automatic check_result();
      result_type want;
      if (expected_results.size() == 0) begin
         report_mismatch("unexpected result", 32'(rsp_mon.data_byte), 32'd0);
         return;
      end
      want = expected_results.pop_front();
      if (rsp_mon.data_byte !== want.data_byte)
         report_mismatch("data_byte", 32'(rsp_mon.data_byte), 32'(want.data_byte));
      if (rsp_mon.is_end !== want.is_end)
         report_mismatch("is_end", 32'(rsp_mon.is_end), 32'(want.is_end));
      if (rsp_mon.status !== want.status)
         report_mismatch("status", 32'(rsp_mon.status), 32'(want.status));
      if (rsp_mon.seq_number !== want.seq_number)
         report_mismatch("seq_number", 32'(rsp_mon.seq_number), 32'(want.seq_number));
      if (rsp_mon.packet_length !== want.packet_length)
         report_mismatch("packet_length", 32'(rsp_mon.packet_length),
                         32'(want.packet_length));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         reset_deframer();
      end else begin
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) check_result();
         if (csr_write_enable) begin
            case (csr_index)
               CSR_START_MARKER:   cfg.start_marker = csr_write_data[7:0];
               CSR_END_MARKER:     cfg.end_marker = csr_write_data[7:0];
               CSR_HUNT_FOR_START: cfg.hunt_for_start = csr_write_data[0];
               default: ;
            endcase
         end
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) deframe_byte(req_mon.rx_byte);
      end
      pending_count <= expected_results.size();
   end

endmodule

/* test/marker_framed_packet_receiver_core_tb.sv */
`timescale 1ns / 1ps
module marker_framed_packet_receiver_core_tb;
   import mfpr_pkg::*;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED_INDEX = 2'd3;
   localparam int PHASE_BYTES = 405;
   localparam int HOLD_CYCLES = 80;

   typedef enum int {
      PKT_GOOD,
      PKT_BAD_CHECK,
      PKT_BAD_END,
      PKT_SHORT,
      PKT_LONE_FF
   } packet_kind_type;

   logic                       clock;
   logic                       reset;
   logic                       csr_write_enable;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_write_data;
   int                         mismatch_count;
   int                         pending_count;
   int                         tx_idle_pct;
   int                         rx_stall_pct;
   int                         hold_trigger;
   int                         hold_seen;
   int                         hold_left;
   int                         bytes_sent;
   int                         drain_cycles;
   cfg_type                    cfg_now;

   mfpr_req_if req_chan();
   mfpr_rsp_if rsp_chan();

   marker_framed_packet_receiver_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   marker_framed_packet_receiver_core_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_chan),
      .rsp_mon          (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .mismatch_count   (mismatch_count),
      .pending_count    (pending_count)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      #2000000;
      $display("** marker_framed_packet_receiver_core: FAILED **");
      $finish;
   end

   // The receiver holds off for a whole stretch whenever the trigger moves.
   initial begin
      hold_seen = 0;
      hold_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_trigger != hold_seen) begin
            hold_seen = hold_trigger;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= rx_stall_pct);
         end
      end
   end

   task automatic send_byte(input logic [7:0] value, input bit counted);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.rx_byte <= value;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      if (counted) bytes_sent++;
   endtask

   task automatic wait_drained(input int extra);
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (extra) @(posedge clock);
   endtask

   task automatic apply_settings(input logic [7:0] start_byte, input logic [7:0] end_byte,
                                 input logic hunt);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_START_MARKER;
      csr_write_data   <= start_byte;
      @(posedge clock);
      csr_index      <= CSR_END_MARKER;
      csr_write_data <= end_byte;
      @(posedge clock);
      csr_index      <= CSR_HUNT_FOR_START;
      csr_write_data <= {7'($urandom_range(127)), hunt};
      @(posedge clock);
      csr_index      <= CSR_UNUSED_INDEX;
      csr_write_data <= 8'($urandom_range(255));
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cfg_now.start_marker   = start_byte;
      cfg_now.end_marker     = end_byte;
      cfg_now.hunt_for_start = hunt;
   endtask

   task automatic send_packet(input packet_kind_type kind, input int payload_len,
                              input int ff_pct);
      logic [7:0]  kept[$];
      logic [7:0]  first;
      logic [7:0]  seq;
      logic [7:0]  b;
      logic [15:0] flen;
      logic [15:0] sum;
      logic [15:0] chk;
      int          residue;
      int          i;
      first = cfg_now.hunt_for_start ? cfg_now.start_marker : 8'($urandom_range(255));
      seq   = 8'($urandom_range(255));
      flen  = (kind == PKT_SHORT) ? 16'($urandom_range(6)) : 16'(payload_len + 7);
      sum   = 16'(first) + 16'(seq) + 16'(flen[15:8]) + 16'(flen[7:0]);
      send_byte(first, 1'b1);
      send_byte(seq, 1'b1);
      send_byte(flen[15:8], 1'b1);
      send_byte(flen[7:0], 1'b1);
      if (kind == PKT_SHORT) return;
      for (i = 0; i < payload_len; i++) begin
         b = ($urandom_range(99) < ff_pct) ? STUFF_BYTE : 8'($urandom_range(255));
         kept.push_back(b);
         sum = sum + 16'(b);
      end
      if (kind == PKT_BAD_END) begin
         chk = 16'($urandom_range(65535));
      end else if (kind == PKT_BAD_CHECK) begin
         residue = (int'(sum) % 255 + int'($urandom_range(254, 1))) % 255;
         chk = 16'(residue + 255 * int'($urandom_range(256)));
      end else if ($urandom_range(1) == 0) begin
         chk = sum;
      end else begin
         chk = 16'(int'(sum) % 255 + 255 * int'($urandom_range(256)));
      end
      kept.push_back(chk[15:8]);
      kept.push_back(chk[7:0]);
      if (kind == PKT_BAD_END)
         kept.push_back(cfg_now.end_marker ^ 8'($urandom_range(255, 1)));
      else
         kept.push_back(cfg_now.end_marker);
      for (i = 0; i < kept.size(); i++) begin
         send_byte(kept[i], 1'b1);
         if (kept[i] == STUFF_BYTE && i + 1 < kept.size()) begin
            if (kept[i+1] == STUFF_BYTE || kind != PKT_LONE_FF || $urandom_range(1) == 0)
               send_byte(STUFF_BYTE, 1'b1);
         end
      end
   endtask

   task automatic run_phase(input int tx_pct, input int rx_pct, input bit pressure);
      int              first_count;
      int              pick;
      int              n;
      bit              paused;
      logic [7:0]      noise;
      packet_kind_type kind;
      tx_idle_pct  = tx_pct;
      rx_stall_pct = rx_pct;
      first_count  = bytes_sent;
      paused       = 1'b0;
      if (pressure) begin
         hold_trigger++;
         send_packet(PKT_GOOD, 120, 50);
      end
      while (bytes_sent - first_count < PHASE_BYTES) begin
         if (pressure && !paused && bytes_sent - first_count >= PHASE_BYTES / 2) begin
            wait_drained(0);
            paused = 1'b1;
         end
         pick = $urandom_range(99);
         if (cfg_now.hunt_for_start && pick < 10) begin
            n = $urandom_range(4, 1);
            repeat (n) begin
               do noise = 8'($urandom_range(255)); while (noise == cfg_now.start_marker);
               send_byte(noise, 1'b0);
            end
         end
         pick = $urandom_range(99);
         if (pick < 66) kind = PKT_GOOD;
         else if (pick < 76) kind = PKT_BAD_CHECK;
         else if (pick < 84) kind = PKT_BAD_END;
         else if (pick < 92) kind = PKT_SHORT;
         else kind = PKT_LONE_FF;
         send_packet(kind, $urandom_range(20), (kind == PKT_LONE_FF) ? 40 : 15);
      end
      wait_drained(4);
   endtask

   initial begin
      reset            <= 1'b1;
      req_chan.valid   <= 1'b0;
      req_chan.rx_byte <= '0;
      csr_write_enable <= 1'b0;
      csr_index        <= CSR_START_MARKER;
      csr_write_data   <= '0;
      tx_idle_pct  = 0;
      rx_stall_pct = 0;
      hold_trigger = 0;
      bytes_sent   = 0;
      cfg_now.start_marker   = RESET_START_MARKER;
      cfg_now.end_marker     = RESET_END_MARKER;
      cfg_now.hunt_for_start = RESET_HUNT_FOR_START;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_byte(8'h00, 1'b0);
      send_byte(8'hff, 1'b0);
      send_packet(PKT_SHORT, 0, 0);
      send_packet(PKT_GOOD, 0, 0);
      send_packet(PKT_BAD_END, 2, 100);
      wait_drained(4);

      apply_settings(8'h00, 8'hff, 1'b0);
      run_phase(0, 0, 1'b1);
      apply_settings(8'hff, 8'h00, 1'b1);
      run_phase(46, 0, 1'b1);
      apply_settings(8'($urandom_range(255)), 8'($urandom_range(255)), 1'b1);
      run_phase(0, 46, 1'b0);
      apply_settings(8'($urandom_range(255)), 8'($urandom_range(255)), 1'($urandom_range(1)));
      run_phase(25, 25, 1'b0);

      req_chan.valid <= 1'b0;
      drain_cycles = 0;
      do begin
         @(posedge clock);
         drain_cycles++;
      end while (pending_count != 0 && drain_cycles < 2000);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("** marker_framed_packet_receiver_core: PASSED **");
      end else begin
         $display("** marker_framed_packet_receiver_core: FAILED **");
      end
      $finish;
   end

endmodule

/* marker_framed_packet_receiver_core.f */
rtl/core/mfpr_pkg.sv
rtl/core/mfpr_if.sv
rtl/core/mfpr_csr.sv
rtl/core/mfpr_in_stage.sv
rtl/core/mfpr_deframer.sv
rtl/core/mfpr_out_reg.sv
rtl/core/marker_framed_packet_receiver_core.sv
rtl/core/mfpr_checker.sv
test/marker_framed_packet_receiver_core_checker.sv
test/marker_framed_packet_receiver_core_tb.sv
